@@ sv/color_key_dot_centroid_defines.svh @@
// Assertion macros shared by the color key dot centroid checker.
// No dependencies; included by the files that assert.
`ifndef COLOR_KEY_DOT_CENTROID_DEFINES_SVH
`define COLOR_KEY_DOT_CENTROID_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CKDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CKDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ckdc_pkg.sv @@
// Shared types and constants of the color key dot centroid block.
// No dependencies; imported by every module of the block.
package ckdc_pkg;

    localparam int COLOR_W     = 8;
    localparam int TOL_W       = 9;
    localparam int ORIGIN_W    = 10;
    localparam int CFG_WIDTH_W = 11;
    localparam int CENT_W      = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_ADDR_W  = 3;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 24;
    localparam int M_USER_W    = 1;
    localparam int SQ_W        = 16;
    localparam int DIST_W      = 18;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DOT_RED         = 3'd0,
        REG_DOT_GREEN       = 3'd1,
        REG_DOT_BLUE        = 3'd2,
        REG_COLOR_TOLERANCE = 3'd3,
        REG_REGION_LEFT     = 3'd4,
        REG_REGION_TOP      = 3'd5,
        REG_REGION_WIDTH    = 3'd6
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_RUN    = 5'b00001,
        ST_DRAIN  = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_WRITE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_div;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/color_key_dot_centroid.sv @@
// Top level of the color key dot centroid block.
// Depends on ckdc_pkg, ckdc_ctrl and ckdc_datapath.
//
//   Channel   Direction  Beat contents
//   s_*       in         tdata: pixel_red, pixel_green, pixel_blue; tlast: region_end
//   m_*       out        tdata: centroid_x, centroid_y; tuser: dot_found
//   cfg_*     in         register index and write data, one write per enabled cycle
//
// Within a region one pixel beat is taken every cycle.
// After the last pixel of a region the input stalls through the drain, load, divide and
// write states, while the bit-serial restoring dividers run; longer if the
// previous result has not yet been taken. A waiting result does not stall pixels.
// Reset is synchronous and active low; it clears the registers to their defaults.
module color_key_dot_centroid #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ckdc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ckdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16]
    input  logic [ckdc_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // centroid_x [10:0], centroid_y [21:11], zero [23:22]
    output logic [ckdc_pkg::M_DATA_W-1:0]       m_tdata,
    // dot_found [0]
    output logic [ckdc_pkg::M_USER_W-1:0]       m_tuser
);
    import ckdc_pkg::*;

    localparam int DIV_STEPS = 3 * $clog2(MAX_DIM);

    dp_cmd_t    cmd;
    dp_status_t status;

    ckdc_ctrl #(
        .DIV_STEPS(DIV_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ckdc_datapath #(
        .MAX_DIM(MAX_DIM)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ sv/ckdc_ctrl.sv @@
// Controller of the color key dot centroid block: region sequencing and divider timing.
// Depends on ckdc_pkg.
module ckdc_ctrl #(
    parameter int DIV_STEPS = 30
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  ckdc_pkg::dp_status_t status,
    output ckdc_pkg::dp_cmd_t    cmd
);
    import ckdc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_RUN);
        unique case (state_reg)
            ST_RUN: begin
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_div = 1'b1;
                step_next    = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ sv/ckdc_datapath.sv @@
// Datapath of the color key dot centroid block: registers, color match, accumulators,
// restoring dividers and the output register. Depends on ckdc_pkg.
module ckdc_datapath #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ckdc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ckdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [ckdc_pkg::S_DATA_W-1:0]       s_tdata,
    input  ckdc_pkg::dp_cmd_t                   cmd,
    output ckdc_pkg::dp_status_t                status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [ckdc_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [ckdc_pkg::M_USER_W-1:0]       m_tuser
);
    import ckdc_pkg::*;

    localparam int CW     = $clog2(MAX_DIM);
    localparam int WW     = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;
    localparam int NUM_W  = 2 * CW + 1;
    localparam int SUM_W  = 3 * CW;
    localparam int OW     = ((CW > ORIGIN_W) ? CW : ORIGIN_W) + 1;
    localparam int PAD_W  = M_DATA_W - 2 * CENT_W;
    localparam logic [NUM_W-1:0] CNT_LIMIT = NUM_W'(MAX_DIM * MAX_DIM);
    localparam logic [WW-1:0]    W_MAX     = WW'(MAX_DIM);
    localparam logic [CW:0]      ROW_LIMIT = (CW + 1)'(MAX_DIM);

    logic [COLOR_W-1:0]     dot_red_reg, dot_green_reg, dot_blue_reg;
    logic [DIST_W-1:0]      tol_sq_reg;
    logic [ORIGIN_W-1:0]    region_left_reg, region_top_reg;
    logic [CFG_WIDTH_W-1:0] region_width_reg;
    logic [DIST_W-1:0]      tol_ext;

    assign tol_ext = DIST_W'(cfg_data[TOL_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_red_reg      <= '0;
            dot_green_reg    <= '0;
            dot_blue_reg     <= '0;
            tol_sq_reg       <= '0;
            region_left_reg  <= '0;
            region_top_reg   <= '0;
            region_width_reg <= CFG_WIDTH_W'(1);
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_DOT_RED:         dot_red_reg      <= cfg_data[COLOR_W-1:0];
                REG_DOT_GREEN:       dot_green_reg    <= cfg_data[COLOR_W-1:0];
                REG_DOT_BLUE:        dot_blue_reg     <= cfg_data[COLOR_W-1:0];
                REG_COLOR_TOLERANCE: tol_sq_reg       <= tol_ext * tol_ext;
                REG_REGION_LEFT:     region_left_reg  <= cfg_data[ORIGIN_W-1:0];
                REG_REGION_TOP:      region_top_reg   <= cfg_data[ORIGIN_W-1:0];
                REG_REGION_WIDTH:    region_width_reg <= cfg_data[CFG_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    logic [COLOR_W-1:0] pix_r, pix_g, pix_b;
    logic [SQ_W-1:0]    dr, dg, db;

    assign pix_r = s_tdata[COLOR_W-1:0];
    assign pix_g = s_tdata[2*COLOR_W-1:COLOR_W];
    assign pix_b = s_tdata[3*COLOR_W-1:2*COLOR_W];
    assign dr = SQ_W'((pix_r > dot_red_reg) ? pix_r - dot_red_reg : dot_red_reg - pix_r);
    assign dg = SQ_W'((pix_g > dot_green_reg) ? pix_g - dot_green_reg : dot_green_reg - pix_g);
    assign db = SQ_W'((pix_b > dot_blue_reg) ? pix_b - dot_blue_reg : dot_blue_reg - pix_b);

    logic [CW-1:0]   col_reg, col_next, row_reg, row_next;
    logic [WW-1:0]   w_cfg, w_eff, col_inc;
    logic [CW:0]     row_inc;

    assign w_cfg   = WW'(region_width_reg);
    assign w_eff   = (w_cfg == '0) ? WW'(1) : ((w_cfg > W_MAX) ? W_MAX : w_cfg);
    assign col_inc = WW'(col_reg) + 1'b1;
    assign row_inc = (CW + 1)'(row_reg) + 1'b1;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.load_div) begin
            col_next = '0;
            row_next = '0;
        end else if (cmd.accept) begin
            if (col_inc >= w_eff) begin
                col_next = '0;
                if (row_inc < ROW_LIMIT) begin
                    row_next = row_inc[CW-1:0];
                end
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    logic            s1_valid_reg;
    logic [SQ_W-1:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic [CW-1:0]   s1_col_reg, s1_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= cmd.accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sq_r_reg   <= dr * dr;
            sq_g_reg   <= dg * dg;
            sq_b_reg   <= db * db;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    logic [DIST_W-1:0] dist_sq;
    logic              hit;
    logic [NUM_W-1:0]  count_reg;
    logic [SUM_W-1:0]  col_sum_reg, row_sum_reg;

    assign dist_sq = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign hit     = s1_valid_reg && (dist_sq < tol_sq_reg) && (count_reg < CNT_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
        end else if (cmd.load_div) begin
            count_reg   <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
        end else if (hit) begin
            count_reg   <= count_reg + 1'b1;
            col_sum_reg <= col_sum_reg + SUM_W'(s1_col_reg);
            row_sum_reg <= row_sum_reg + SUM_W'(s1_row_reg);
        end
    end

    logic [SUM_W-1:0] numx_reg, numy_reg;
    logic [NUM_W-1:0] remx_reg, remy_reg, den_reg;
    logic             found_reg;
    logic [NUM_W:0]   trial_x, trial_y, den_ext;
    logic             ge_x, ge_y;

    assign den_ext = {1'b0, den_reg};
    assign trial_x = {remx_reg, numx_reg[SUM_W-1]};
    assign trial_y = {remy_reg, numy_reg[SUM_W-1]};
    assign ge_x    = (trial_x >= den_ext);
    assign ge_y    = (trial_y >= den_ext);

    always_ff @(posedge aclk) begin
        if (cmd.load_div) begin
            numx_reg  <= col_sum_reg;
            numy_reg  <= row_sum_reg;
            den_reg   <= count_reg;
            remx_reg  <= '0;
            remy_reg  <= '0;
            found_reg <= (count_reg != '0);
        end else if (cmd.div_step) begin
            numx_reg <= {numx_reg[SUM_W-2:0], ge_x};
            numy_reg <= {numy_reg[SUM_W-2:0], ge_y};
            remx_reg <= ge_x ? NUM_W'(trial_x - den_ext) : trial_x[NUM_W-1:0];
            remy_reg <= ge_y ? NUM_W'(trial_y - den_ext) : trial_y[NUM_W-1:0];
        end
    end

    logic [OW-1:0]             cx_full, cy_full;
    logic                      m_tvalid_reg;
    logic [M_DATA_W-1:0]       m_tdata_reg;
    logic [M_USER_W-1:0]       m_tuser_reg;

    assign cx_full = OW'(numx_reg[CW-1:0]) + OW'(region_left_reg);
    assign cy_full = OW'(numy_reg[CW-1:0]) + OW'(region_top_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tuser_reg <= M_USER_W'(found_reg);
            if (found_reg) begin
                m_tdata_reg <= {{PAD_W{1'b0}}, cy_full[CENT_W-1:0], cx_full[CENT_W-1:0]};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ sv/ckdc_checker.sv @@
// Port-level checker of the color key dot centroid block, bound to the top level.
// Depends on ckdc_pkg and color_key_dot_centroid_defines.svh.
`include "color_key_dot_centroid_defines.svh"

module ckdc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ckdc_pkg::M_DATA_W-1:0] m_tdata,
    input logic [ckdc_pkg::M_USER_W-1:0] m_tuser
);
    import ckdc_pkg::*;

    // A stalled result beat keeps its contents.
    `CKDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // A not-found result carries zero coordinates.
    `CKDC_ASSERT_NOW(a_not_found_zero, m_tvalid && (m_tuser == '0), m_tdata == '0, "not-found result with nonzero coordinates")

    // The last pixel of a region stops the input while the centroid is computed.
    `CKDC_ASSERT_NEXT(a_end_stall, s_tvalid && s_tready && s_tlast, !s_tready, "input not stalled after region end")

    // A new result only appears at the end of a stall of the input.
    `CKDC_ASSERT_NOW(a_result_after_stall, $rose(m_tvalid), $past(!s_tready), "result appeared without an input stall")

endmodule

bind color_key_dot_centroid ckdc_checker u_checker (.*);
